FILE: rtl/sprc_pkg.sv
// Shared types and constants for the stepper pulse-rate calculator.
// No dependencies.
package sprc_pkg;

	localparam int DIST_W  = 40;
	localparam int STEP_W  = 32;
	localparam int CNT_W   = 17;
	localparam int SPUL_W  = 18;
	localparam int FRAC_W  = 8;
	localparam int DIR_W   = 2;
	localparam int AXIS_W  = 2;
	localparam int NUM_REGS = 3;

	localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_W-1:0] DIR_POS  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_NEG  = 2'd2;

	localparam logic [AXIS_W-1:0] REG_STEP_X = 2'd0;
	localparam logic [AXIS_W-1:0] REG_STEP_Y = 2'd1;
	localparam logic [AXIS_W-1:0] REG_STEP_Z = 2'd2;

	localparam logic [STEP_W-1:0] STEP_RESET = 32'd52429;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_CMP,
		ST_DIV1,
		ST_PCNT,
		ST_DIV2,
		ST_DIV3,
		ST_UPD,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item and residual
		logic sum;       // residual + displacement, saturate, write back
		logic cmp;       // classify ratio against limits
		logic div_start; // start shared divider
		logic div_sel1;  // operands for m / s
		logic div_sel2;  // operands for CLK / pulses
		logic div_sel3;  // operands for 256*r / pulses
		logic pcnt;      // settle pulse count
		logic qset;      // capture pulse count from quotient of m / s
		logic upd;       // subtract emitted distance, form result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic stop;      // result is stop, skip the rest
		logic need_div;  // pulse count comes from m / s
		logic div_busy;
	} dp_stat_t;

endpackage

FILE: rtl/sprc_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on sprc_pkg.
module sprc_divider #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         busy,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	import sprc_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quot_q, rem_q, den_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quot_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				rem_q  <= trial[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[W-2:0], quot_q[W-1]};
				quot_q <= {quot_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/sprc_datapath.sv
// Datapath: step registers, residual store, limits and result registers.
// Depends on sprc_pkg and sprc_divider.
module sprc_datapath #(
	parameter int CLOCKS_PER_PERIOD = 131072,
	parameter int RATIO_MAX = 65536,
	parameter int RATIO_MIN = 2,
	parameter int AXES = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sprc_pkg::AXIS_W-1:0]       cfg_idx,
	input  logic [sprc_pkg::STEP_W-1:0]       cfg_data,
	input  logic [sprc_pkg::AXIS_W-1:0]       axis_sel,
	input  logic signed [sprc_pkg::DIST_W-1:0] period_dist,
	input  sprc_pkg::dp_cmd_t                 cmd,
	output sprc_pkg::dp_stat_t                stat,
	output logic [sprc_pkg::DIR_W-1:0]        move_dir,
	output logic [sprc_pkg::CNT_W-1:0]        pulse_count,
	output logic signed [sprc_pkg::SPUL_W-1:0] signed_pulses,
	output logic [sprc_pkg::CNT_W-1:0]        timer_divider,
	output logic [sprc_pkg::FRAC_W-1:0]       divider_frac
);
	import sprc_pkg::*;

	localparam int DW = 64;
	localparam int AIW = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int EW = CNT_W + STEP_W;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam longint P_HI = (2 * longint'(CLOCKS_PER_PERIOD) + RATIO_MAX)
		/ (2 * longint'(RATIO_MAX));
	localparam longint P_LO = (2 * longint'(CLOCKS_PER_PERIOD) + RATIO_MIN)
		/ (2 * longint'(RATIO_MIN));
	localparam logic [CNT_W-1:0] PULSE_HI = (P_HI > 131071) ? CNT_MAX : CNT_W'(P_HI);
	localparam logic [CNT_W-1:0] PULSE_LO = (P_LO > 131071) ? CNT_MAX : CNT_W'(P_LO);
	localparam logic signed [DIST_W+1:0] RES_MAX = {3'b000, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W+1:0] RES_MIN = {3'b111, {(DIST_W-1){1'b0}}};
	// anything beyond 2^40 saturates the residual just the same
	localparam logic [EW-1:0] EMIT_CAP = EW'(1) << DIST_W;

	logic [STEP_W-1:0] step_q [NUM_REGS];
	logic signed [DIST_W-1:0] resid_q [AXES];

	logic [AXIS_W-1:0]        axis_q;
	logic                     axis_ok_q;
	logic signed [DIST_W-1:0] dist_q, res_q;
	logic [DIST_W-1:0]        mag_q;
	logic                     neg_q, stop_q, need_div_q;
	logic [STEP_W-1:0]        s_q;
	logic [CNT_W-1:0]         pulses_q;
	logic [CNT_W-1:0]         tq_q;
	logic                     qz_q;
	logic [CNT_W-1:0]         rem_q;
	logic [2*STEP_W-1:0]      lhs_q, rhs_max_q;

	logic                     div_start;
	logic [DW-1:0]            div_num, div_den, div_quot, div_rem;
	logic                     div_busy;

	logic signed [DIST_W+1:0] sum_w, upd_w;
	logic signed [DIST_W-1:0] sat_w;
	logic [EW-1:0]            emit_full_w;
	logic signed [DIST_W+1:0] emit_w;
	logic [DIST_W-1:0]        mag_w;
	logic [DW-1:0]            qfull_w;

	// step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) step_q[i] <= STEP_RESET;
		end else if (cfg_we && cfg_idx < AXIS_W'(NUM_REGS)) begin
			step_q[cfg_idx] <= cfg_data;
		end
	end

	function automatic logic signed [DIST_W-1:0] sat40(input logic signed [DIST_W+1:0] v);
		if (v > RES_MAX) return RES_MAX[DIST_W-1:0];
		else if (v < RES_MIN) return RES_MIN[DIST_W-1:0];
		else return v[DIST_W-1:0];
	endfunction

	assign sum_w  = DIST_W'(0) + {{2{res_q[DIST_W-1]}}, res_q} + {{2{dist_q[DIST_W-1]}}, dist_q};
	assign sat_w  = sat40(sum_w);
	// magnitude of the saturated sum; -2^39 gives 2^39 in 40 unsigned bits
	assign mag_w  = sat_w[DIST_W-1] ? DIST_W'(-sat_w) : sat_w;
	assign emit_full_w = EW'(pulses_q) * EW'(s_q);
	assign emit_w = (emit_full_w > EMIT_CAP) ? (DIST_W+2)'(EMIT_CAP)
	                                         : (DIST_W+2)'(emit_full_w);
	assign upd_w  = neg_q ? ({{2{res_q[DIST_W-1]}}, res_q} + emit_w)
	                      : ({{2{res_q[DIST_W-1]}}, res_q} - emit_w);

	// residual store; one entry per axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) resid_q[i] <= '0;
		end else if (axis_ok_q && cmd.sum) begin
			resid_q[AIW'(axis_q)] <= sat_w;
		end else if (axis_ok_q && cmd.upd && !stop_q) begin
			resid_q[AIW'(axis_q)] <= sat40(upd_w);
		end
	end

	// rounding: (2m + s) / (2s) equals (m + s/2) / s done as quotient of
	// 2m+s over 2s; the divider is 64 bits so both fit.
	always_comb begin
		div_start = cmd.div_start;
		div_num = '0;
		div_den = 64'd1;
		if (cmd.div_sel1) begin
			div_num = (DW'(mag_q) << 1) + DW'(s_q);
			div_den = DW'(s_q) << 1;
		end else if (cmd.div_sel2) begin
			div_num = DW'(CLOCKS_PER_PERIOD);
			div_den = DW'(pulses_q);
		end else if (cmd.div_sel3) begin
			// remainder of CLK / pulses is still held in the divider at start
			div_num = DW'(div_rem[CNT_W-1:0]) << FRAC_W;
			div_den = DW'(pulses_q);
		end
	end

	sprc_divider #(.W(DW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	assign qfull_w = div_quot;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			axis_q    <= axis_sel;
			axis_ok_q <= (axis_sel < AXIS_W'(NUM_REGS)) && (32'(axis_sel) < AXES);
			dist_q    <= period_dist;
			res_q     <= resid_q[AIW'(axis_sel)];
			s_q       <= step_q[axis_sel];
			stop_q    <= 1'b0;
		end
		if (cmd.sum) begin
			res_q <= sat_w;
			mag_q <= mag_w;
			neg_q <= sum_w[DIST_W+1];
			lhs_q <= (2*STEP_W)'(CLOCKS_PER_PERIOD) * (2*STEP_W)'(s_q);
			stop_q <= !axis_ok_q || (s_q == '0) || (mag_w < DIST_W'(s_q));
		end
		if (cmd.cmp) begin
			rhs_max_q <= (2*STEP_W)'(RATIO_MAX) * (2*STEP_W)'(mag_q);
		end
		if (cmd.pcnt) begin
			// clamp decision is made here using staged products
			if (lhs_q > rhs_max_q) begin
				pulses_q <= PULSE_HI;
				need_div_q <= 1'b0;
			end else if (lhs_q <= (2*STEP_W)'(RATIO_MIN) * (2*STEP_W)'(mag_q)) begin
				pulses_q <= PULSE_LO;
				need_div_q <= 1'b0;
			end else begin
				need_div_q <= 1'b1;
			end
		end
		if (cmd.qset) begin
			if (need_div_q) begin
				pulses_q <= (qfull_w > DW'(CNT_MAX)) ? CNT_MAX : qfull_w[CNT_W-1:0];
				if (qfull_w == '0) stop_q <= 1'b1;
			end else if (pulses_q == '0) begin
				stop_q <= 1'b1;
			end
		end
		if (cmd.div_sel3 && cmd.div_start) begin
			// latched quotient/remainder of CLK / pulses
			qz_q <= (div_quot == '0);
			if (div_quot == '0) tq_q <= '0;
			else if (div_quot - 1 > DW'(CNT_MAX)) tq_q <= CNT_MAX;
			else tq_q <= CNT_W'(div_quot - 1);
			rem_q <= div_rem[CNT_W-1:0];
		end
		if (cmd.div_sel2 && cmd.div_start) begin
			need_div_q <= 1'b0;
		end
		if (cmd.upd) begin
			if (stop_q || !axis_ok_q) begin
				move_dir      <= DIR_STOP;
				pulse_count   <= '0;
				signed_pulses <= '0;
				timer_divider <= '0;
				divider_frac  <= '0;
			end else begin
				move_dir      <= neg_q ? DIR_NEG : DIR_POS;
				pulse_count   <= pulses_q;
				signed_pulses <= neg_q ? -SPUL_W'(pulses_q) : SPUL_W'(pulses_q);
				timer_divider <= tq_q;
				divider_frac  <= qz_q ? '0 : div_quot[FRAC_W-1:0];
			end
		end
	end

	assign stat.stop     = stop_q;
	assign stat.need_div = need_div_q;
	assign stat.div_busy = div_busy;

	logic unused_w;
	assign unused_w = ^rem_q;

endmodule

FILE: rtl/sprc_ctrl.sv
// Controller: sequences one item through the datapath and the output handshake.
// Depends on sprc_pkg.
module sprc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sprc_pkg::dp_stat_t stat,
	output sprc_pkg::dp_cmd_t  cmd
);
	import sprc_pkg::*;

	state_t state_q, state_d;
	logic   started_q, started_d;
	logic   ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			started_q <= started_d;
			ov_q      <= ov_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		started_d = 1'b0;
		ov_d      = ov_q;
		cmd       = '0;
		in_ready  = 1'b0;
		if (ov_q && out_ready) ov_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = stat.stop ? ST_OUT : ST_PCNT;
			end
			ST_PCNT: begin
				cmd.pcnt = 1'b1;
				state_d = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_sel1 = 1'b1;
				if (!stat.need_div) begin
					cmd.qset = 1'b1;
					state_d = ST_DIV2;
				end else if (!started_q) begin
					cmd.div_start = 1'b1;
					started_d = 1'b1;
				end else if (!stat.div_busy) begin
					cmd.qset = 1'b1;
					state_d = ST_DIV2;
				end else begin
					started_d = 1'b1;
				end
			end
			ST_DIV2: begin
				cmd.div_sel2 = 1'b1;
				if (stat.stop) begin
					state_d = ST_OUT;
				end else if (!started_q) begin
					cmd.div_start = 1'b1;
					started_d = 1'b1;
				end else if (!stat.div_busy) begin
					state_d = ST_DIV3;
				end else begin
					started_d = 1'b1;
				end
			end
			ST_DIV3: begin
				cmd.div_sel3 = 1'b1;
				if (!started_q) begin
					cmd.div_start = 1'b1;
					started_d = 1'b1;
				end else if (!stat.div_busy) begin
					state_d = ST_OUT;
				end else begin
					started_d = 1'b1;
				end
			end
			ST_OUT: begin
				if (!ov_d) begin
					cmd.upd = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = ov_q;

`ifndef ASSERT_OFF
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE) else $error("load outside idle");
	a_ov_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> ov_q) else $error("result dropped");
	a_upd_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> !ov_q || out_ready) else $error("result overwritten");
`endif

endmodule

FILE: rtl/stepper_pulse_rate_calc.sv
// Top level of the stepper pulse-rate calculator.
// Depends on sprc_pkg, sprc_ctrl, sprc_datapath and sprc_divider.
//
// One item (axis, displacement) adds to that axis's residual and yields one
// result: direction, rounded pulse count, signed pulses and timer divider
// with an 8-bit fraction. Items are handled one at a time; the shared
// 64-bit restoring divider, one quotient bit per cycle, is used up to
// three times per item (residual over step, clocks over pulses, remainder
// fraction). The result register frees the input side: the next item is
// taken while a result still waits. Step lengths are to be written by the
// user through cfg_we/cfg_idx/cfg_data only while the block is idle; the
// block itself does not enforce this.
module stepper_pulse_rate_calc #(
	parameter int CLOCKS_PER_PERIOD = 131072,
	parameter int RATIO_MAX = 65536,
	parameter int RATIO_MIN = 2,
	parameter int AXES = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sprc_pkg::AXIS_W-1:0]        cfg_idx,
	input  logic [sprc_pkg::STEP_W-1:0]        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sprc_pkg::AXIS_W-1:0]        axis_sel,
	input  logic signed [sprc_pkg::DIST_W-1:0] period_dist,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sprc_pkg::DIR_W-1:0]         move_dir,
	output logic [sprc_pkg::CNT_W-1:0]         pulse_count,
	output logic signed [sprc_pkg::SPUL_W-1:0] signed_pulses,
	output logic [sprc_pkg::CNT_W-1:0]         timer_divider,
	output logic [sprc_pkg::FRAC_W-1:0]        divider_frac
);
	import sprc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sprc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sprc_datapath #(
		.CLOCKS_PER_PERIOD(CLOCKS_PER_PERIOD),
		.RATIO_MAX        (RATIO_MAX),
		.RATIO_MIN        (RATIO_MIN),
		.AXES             (AXES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.axis_sel     (axis_sel),
		.period_dist  (period_dist),
		.cmd          (cmd),
		.stat         (stat),
		.move_dir     (move_dir),
		.pulse_count  (pulse_count),
		.signed_pulses(signed_pulses),
		.timer_divider(timer_divider),
		.divider_frac (divider_frac)
	);

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for stepper_pulse_rate_calc: directed and random items with a
// built-in pulse-rate predictor. Depends on sprc_pkg and the block's RTL.
module tb_top;
	import sprc_pkg::*;

	localparam longint CLK_PER = 131072;
	localparam longint R_MAX = 65536;
	localparam longint R_MIN = 2;
	localparam longint RES_HI = 64'sd549755813887;
	localparam longint RES_LO = -64'sd549755813888;

	typedef struct packed {
		logic [DIR_W-1:0]         dir;
		logic [CNT_W-1:0]         cnt;
		logic signed [SPUL_W-1:0] spul;
		logic [CNT_W-1:0]         tdiv;
		logic [FRAC_W-1:0]        frac;
	} pulse_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [AXIS_W-1:0] cfg_idx = '0;
	logic [STEP_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [AXIS_W-1:0] axis_sel = '0;
	logic signed [DIST_W-1:0] period_dist = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DIR_W-1:0] move_dir;
	logic [CNT_W-1:0] pulse_count;
	logic signed [SPUL_W-1:0] signed_pulses;
	logic [CNT_W-1:0] timer_divider;
	logic [FRAC_W-1:0] divider_frac;

	stepper_pulse_rate_calc uut (.*);

	// predictor state
	logic [STEP_W-1:0] step_len [3];
	longint residual [3];
	pulse_res_t pending_q [$];
	int errors = 0;
	int n_items = 0;
	int n_moves = 0;
	bit rx_stall = 1'b1;

	initial forever #5 clk = ~clk;

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	function automatic longint sat40(longint v);
		if (v > RES_HI) return RES_HI;
		if (v < RES_LO) return RES_LO;
		return v;
	endfunction

	function automatic longint rdiv(longint num, longint den);
		return (2 * num + den) / (2 * den);
	endfunction

	// advance the predictor by one item and return its expected result
	function automatic pulse_res_t predict_pulses(logic [1:0] ax, logic signed [39:0] d);
		pulse_res_t r;
		longint res, s, m, p, q, rm;
		bit neg;
		r = '0;
		if (ax == 2'd3) return r;              // invalid axis: no state change
		res = sat40(residual[ax] + longint'(d));
		residual[ax] = res;
		s = longint'(step_len[ax]);
		if (s == 0) return r;
		neg = res < 0;
		m = neg ? -res : res;
		if (m < s) return r;
		// s < 2^32, m < 2^40: products fit in 64 bits
		if (CLK_PER * s > R_MAX * m) p = rdiv(CLK_PER, R_MAX);
		else if (CLK_PER * s <= R_MIN * m) p = rdiv(CLK_PER, R_MIN);
		else p = rdiv(m, s);
		if (p > 131071) p = 131071;
		if (p == 0) return r;
		q = CLK_PER / p;
		rm = CLK_PER % p;
		if (q == 0) begin
			r.tdiv = '0;
			r.frac = '0;
		end else begin
			q = q - 1;
			if (q > 131071) q = 131071;
			r.tdiv = q[CNT_W-1:0];
			r.frac = 8'((rm * 256) / p);
		end
		residual[ax] = neg ? sat40(res + p * s) : sat40(res - p * s);
		r.dir = neg ? DIR_NEG : DIR_POS;
		r.cnt = p[CNT_W-1:0];
		r.spul = neg ? SPUL_W'(-p) : SPUL_W'(p);
		return r;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// valid stays high into the next item when there is no gap
	task automatic send_item(logic [1:0] ax, logic signed [39:0] d);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		axis_sel <= ax;
		period_dist <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_q.push_back(predict_pulses(ax, d));
		n_items++;
	endtask

	// wait for all results, then a margin so the block is idle
	task automatic drain();
		int t;
		t = 0;
		in_valid <= 1'b0;
		while (pending_q.size() != 0 && t < 2000000) begin
			@(posedge clk);
			t++;
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic write_step(logic [1:0] idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		step_len[idx] = v;
		@(posedge clk);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		pulse_res_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected result dir=%0d cnt=%0d", $time, move_dir,
						pulse_count);
					errors++;
				end else begin
					e = pending_q.pop_front();
					if (e.dir != DIR_STOP) n_moves++;
					if (move_dir !== e.dir || pulse_count !== e.cnt ||
						signed_pulses !== e.spul || timer_divider !== e.tdiv ||
						divider_frac !== e.frac) begin
						$display("%0t: mismatch exp dir=%0d cnt=%0d spul=%0d div=%0d frac=%0d",
							$time, e.dir, e.cnt, e.spul, e.tdiv, e.frac);
						$display("%0t:          act dir=%0d cnt=%0d spul=%0d div=%0d frac=%0d",
							$time, move_dir, pulse_count, signed_pulses, timer_divider,
							divider_frac);
						errors++;
					end
				end
			end
			out_ready <= rx_stall ? (gap_len() == 0) : 1'b1;
		end
	end

	task automatic test_directed();
		send_item(2'd0, 40'sd0);                    // stop, zero
		send_item(2'd0, 40'sd52428);                // just under one step
		send_item(2'd0, 40'sd1);                    // reaches exactly one step
		send_item(2'd1, 40'sh7FFFFFFFFF);           // positive extreme, min ratio
		send_item(2'd1, 40'sh7FFFFFFFFF);           // residual saturates
		send_item(2'd1, -40'sh8000000000);          // negative extreme
		send_item(2'd1, -40'sh8000000000);
		send_item(2'd2, -40'sd52429 * 3);           // negative, small count
		send_item(2'd2, 40'sd52429 * 7 / 2);        // rounding half
		send_item(2'd3, 40'sd123456789);            // invalid axis
		send_item(2'd3, -40'sd1);
		send_item(2'd0, 40'sd52429 * 40000);        // ratio between limits
		send_item(2'd0, 40'sd52429 * 70000);        // beyond min clamp, clamped
		drain();
	endtask

	task automatic test_step_extremes();
		write_step(REG_STEP_X, 32'd1);
		write_step(REG_STEP_Y, 32'hFFFFFFFF);
		write_step(REG_STEP_Z, 32'd0);              // zero step: always stop
		send_item(2'd0, 40'sd1);
		send_item(2'd0, 40'sd70000);
		send_item(2'd1, 40'sd4294967295);           // ratio between limits
		send_item(2'd1, -40'sd549755813887);
		send_item(2'd2, 40'sd99999999);
		send_item(2'd2, -40'sd99999999);
		drain();
	endtask

	task automatic test_random(int n, bit stall);
		int k;
		logic signed [39:0] d;
		logic [1:0] ax;
		rx_stall = stall;
		for (int i = 0; i < n; i++) begin
			ax = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			k = $urandom_range(0, 9);
			if (k < 6) d = 40'($signed(longint'(step_len[ax == 3 ? 0 : ax]))
				* $signed(longint'($urandom_range(0, 70000))));
			else if (k < 8) d = 40'($signed({$urandom, $urandom}));
			else d = 40'($signed(longint'($urandom_range(0, 200000))) - 100000);
			if (k < 6 && $urandom_range(0, 1)) d = -d;
			send_item(ax, d);
			if (i == n / 2) drain();                // hold off until all results in
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			step_len[i] = STEP_RESET;
			residual[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_step_extremes();
		write_step(REG_STEP_X, 32'd52429);
		write_step(REG_STEP_Y, $urandom_range(1000, 9000000));
		write_step(REG_STEP_Z, $urandom);
		test_random(400, 1'b1);
		write_step(REG_STEP_X, $urandom_range(1, 100));
		write_step(REG_STEP_Y, 32'd52429);
		write_step(REG_STEP_Z, 32'hFFFFFFFF);
		test_random(300, 1'b0);
		write_step(REG_STEP_X, 32'd52429);
		write_step(REG_STEP_Y, 32'd52429);
		write_step(REG_STEP_Z, 32'd52429);
		test_random(300, 1'b1);
		if (pending_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_q.size());
			errors++;
		end
		$display("Covered %0d items (%0d moving results), step extremes and invalid axes.",
			n_items, n_moves);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/sprc_pkg.sv
rtl/sprc_divider.sv
rtl/sprc_datapath.sv
rtl/sprc_ctrl.sv
rtl/stepper_pulse_rate_calc.sv
dv/tb_top.sv
